/* rtl/core/lpfm_pkg.sv */
// shared constants and codes for the lru page frame manager
`timescale 1ns / 1ps

package lpfm_pkg;

   localparam int DEF_FRAMES     = 6;
   localparam int DEF_PAGE_WORDS = 256;
   localparam int DEF_INDEX_BITS = 24;

   localparam int INDEX_W  = 24;
   localparam int FRAME_W  = 3;
   localparam int OFFSET_W = 8;
   localparam int PAGE_W   = 16;

   localparam logic OP_ACCESS     = 1'b0;
   localparam logic OP_MARK_DIRTY = 1'b1;

endpackage

/* rtl/core/lru_page_frame_manager.sv */
// top level of the lru page frame manager: request register, frame state and result register
`timescale 1ns / 1ps

// One request is taken per clock: busy is low except while reset is held, and a
// request taken at one edge is looked up and applied to the frame state in the
// following cycle, its result beat standing on the rsp_ ports for one cycle
// from the next edge. The rate of one request per cycle is set by the loop of
// tag compare, victim choice and rank update through the frame state registers.
// Results cannot be held off by the receiver; rsp_strobe marks each beat, which
// must be taken in that cycle. Access (op 0) hits a resident page and makes it
// most recent, or fills the lowest empty frame, else the least recent one,
// reporting a writeback when the evicted frame was dirty. Mark-dirty (op 1)
// sets the dirty bit of a resident page.

module lru_page_frame_manager #(
   parameter int FRAMES     = lpfm_pkg::DEF_FRAMES,
   parameter int PAGE_WORDS = lpfm_pkg::DEF_PAGE_WORDS,
   parameter int INDEX_BITS = lpfm_pkg::DEF_INDEX_BITS
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            start,
   output logic                            busy,
   input  logic                            req_op,
   input  logic [lpfm_pkg::INDEX_W-1:0]    req_index,
   output logic                            rsp_strobe,
   output logic                            rsp_hit,
   output logic [lpfm_pkg::FRAME_W-1:0]    rsp_frame,
   output logic [lpfm_pkg::OFFSET_W-1:0]   rsp_offset,
   output logic [lpfm_pkg::PAGE_W-1:0]     rsp_fill_page,
   output logic                            rsp_writeback,
   output logic [lpfm_pkg::PAGE_W-1:0]     rsp_writeback_page
);

   localparam int FIDX_W     = $clog2(FRAMES);
   localparam int PAGE_SHIFT = $clog2(PAGE_WORDS);
   localparam logic [31:0] INDEX_MASK =
      (INDEX_BITS >= 32) ? 32'hFFFF_FFFF : 32'((64'd1 << INDEX_BITS) - 64'd1);
   localparam logic [31:0] OFFSET_MASK = 32'(PAGE_WORDS - 1);

   // request register
   logic                           req_valid_ff, req_valid_in;
   logic                           req_op_ff;
   logic [lpfm_pkg::INDEX_W-1:0]   req_index_ff;

   // frame state
   logic [lpfm_pkg::PAGE_W-1:0]    frame_page_ff [FRAMES];
   logic [lpfm_pkg::PAGE_W-1:0]    frame_page_in [FRAMES];
   logic [FRAMES-1:0]              frame_valid_ff, frame_valid_in;
   logic [FRAMES-1:0]              frame_dirty_ff, frame_dirty_in;
   logic [FIDX_W-1:0]              rank_ff [FRAMES];
   logic [FIDX_W-1:0]              rank_in [FRAMES];

   // result register
   logic                           rsp_strobe_ff;
   logic                           rsp_hit_ff, rsp_hit_in;
   logic [lpfm_pkg::FRAME_W-1:0]   rsp_frame_ff, rsp_frame_in;
   logic [lpfm_pkg::OFFSET_W-1:0]  rsp_offset_ff, rsp_offset_in;
   logic [lpfm_pkg::PAGE_W-1:0]    rsp_fill_page_ff, rsp_fill_page_in;
   logic                           rsp_writeback_ff, rsp_writeback_in;
   logic [lpfm_pkg::PAGE_W-1:0]    rsp_writeback_page_ff, rsp_writeback_page_in;

   logic [31:0]                    idx_masked;
   logic [lpfm_pkg::PAGE_W-1:0]    page;
   logic                           hit;
   logic [FIDX_W-1:0]              hit_frame;
   logic [FIDX_W-1:0]              victim;
   logic                           touch;
   logic [FIDX_W-1:0]              touch_frame;

   assign busy         = reset;
   assign req_valid_in = start && !busy;

   assign idx_masked = {{(32 - lpfm_pkg::INDEX_W){1'b0}}, req_index_ff} & INDEX_MASK;
   assign page       = lpfm_pkg::PAGE_W'(idx_masked >> PAGE_SHIFT);

   lpfm_tag_match #(
      .FRAMES      (FRAMES)
   ) u_tag_match (
      .page        (page),
      .frame_page  (frame_page_ff),
      .frame_valid (frame_valid_ff),
      .rank        (rank_ff),
      .hit         (hit),
      .hit_frame   (hit_frame),
      .victim      (victim)
   );

   assign touch       = req_valid_ff && (req_op_ff == lpfm_pkg::OP_ACCESS);
   assign touch_frame = hit ? hit_frame : victim;

   lpfm_recency #(
      .FRAMES      (FRAMES)
   ) u_recency (
      .touch       (touch),
      .touch_frame (touch_frame),
      .rank        (rank_ff),
      .rank_next   (rank_in)
   );

   always_comb begin
      frame_page_in         = frame_page_ff;
      frame_valid_in        = frame_valid_ff;
      frame_dirty_in        = frame_dirty_ff;
      rsp_hit_in            = 1'b0;
      rsp_frame_in          = '0;
      rsp_offset_in         = lpfm_pkg::OFFSET_W'(idx_masked & OFFSET_MASK);
      rsp_fill_page_in      = '0;
      rsp_writeback_in      = 1'b0;
      rsp_writeback_page_in = '0;
      if (req_valid_ff) begin
         if (hit) begin
            rsp_hit_in   = 1'b1;
            rsp_frame_in = lpfm_pkg::FRAME_W'(hit_frame);
            if (req_op_ff == lpfm_pkg::OP_MARK_DIRTY) begin
               frame_dirty_in[hit_frame] = 1'b1;
            end
         end else if (req_op_ff == lpfm_pkg::OP_ACCESS) begin
            rsp_frame_in     = lpfm_pkg::FRAME_W'(victim);
            rsp_fill_page_in = page;
            if (frame_valid_ff[victim] && frame_dirty_ff[victim]) begin
               rsp_writeback_in      = 1'b1;
               rsp_writeback_page_in = frame_page_ff[victim];
            end
            frame_page_in[victim]  = page;
            frame_valid_in[victim] = 1'b1;
            frame_dirty_in[victim] = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         req_valid_ff   <= 1'b0;
         rsp_strobe_ff  <= 1'b0;
         frame_valid_ff <= '0;
         frame_dirty_ff <= '0;
         for (int i = 0; i < FRAMES; i++) begin
            frame_page_ff[i] <= '0;
            rank_ff[i]       <= FIDX_W'(i);
         end
      end else begin
         req_valid_ff   <= req_valid_in;
         rsp_strobe_ff  <= req_valid_ff;
         frame_valid_ff <= frame_valid_in;
         frame_dirty_ff <= frame_dirty_in;
         frame_page_ff  <= frame_page_in;
         rank_ff        <= rank_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid_in) begin
         req_op_ff    <= req_op;
         req_index_ff <= req_index;
      end
      rsp_hit_ff            <= rsp_hit_in;
      rsp_frame_ff          <= rsp_frame_in;
      rsp_offset_ff         <= rsp_offset_in;
      rsp_fill_page_ff      <= rsp_fill_page_in;
      rsp_writeback_ff      <= rsp_writeback_in;
      rsp_writeback_page_ff <= rsp_writeback_page_in;
   end

   assign rsp_strobe         = rsp_strobe_ff;
   assign rsp_hit            = rsp_hit_ff;
   assign rsp_frame          = rsp_frame_ff;
   assign rsp_offset         = rsp_offset_ff;
   assign rsp_fill_page      = rsp_fill_page_ff;
   assign rsp_writeback      = rsp_writeback_ff;
   assign rsp_writeback_page = rsp_writeback_page_ff;

endmodule

/* rtl/core/lpfm_tag_match.sv */
// parallel tag compare, hit frame select and victim choice
`timescale 1ns / 1ps

module lpfm_tag_match #(
   parameter int FRAMES = lpfm_pkg::DEF_FRAMES
) (
   input  logic [lpfm_pkg::PAGE_W-1:0]   page,
   input  logic [lpfm_pkg::PAGE_W-1:0]   frame_page [FRAMES],
   input  logic [FRAMES-1:0]             frame_valid,
   input  logic [$clog2(FRAMES)-1:0]     rank [FRAMES],
   output logic                          hit,
   output logic [$clog2(FRAMES)-1:0]     hit_frame,
   output logic [$clog2(FRAMES)-1:0]     victim
);

   localparam int FIDX_W = $clog2(FRAMES);

   logic [FRAMES-1:0] match;
   logic [FIDX_W-1:0] empty_frame;
   logic [FIDX_W-1:0] oldest_frame;

   always_comb begin
      match        = '0;
      hit_frame    = '0;
      empty_frame  = '0;
      oldest_frame = '0;
      for (int i = 0; i < FRAMES; i++) begin
         match[i] = frame_valid[i] && (frame_page[i] == page);
      end
      // lowest index wins, so walk downwards
      for (int i = FRAMES - 1; i >= 0; i--) begin
         if (match[i]) begin
            hit_frame = FIDX_W'(i);
         end
         if (!frame_valid[i]) begin
            empty_frame = FIDX_W'(i);
         end
         if (rank[i] == '0) begin
            oldest_frame = FIDX_W'(i);
         end
      end
      hit    = |match;
      victim = (&frame_valid) ? oldest_frame : empty_frame;
   end

endmodule

/* rtl/core/lpfm_recency.sv */
// recency rank update that moves one frame to most recent
`timescale 1ns / 1ps

module lpfm_recency #(
   parameter int FRAMES = lpfm_pkg::DEF_FRAMES
) (
   input  logic                        touch,
   input  logic [$clog2(FRAMES)-1:0]   touch_frame,
   input  logic [$clog2(FRAMES)-1:0]   rank [FRAMES],
   output logic [$clog2(FRAMES)-1:0]   rank_next [FRAMES]
);

   localparam int FIDX_W = $clog2(FRAMES);
   localparam logic [FIDX_W-1:0] TOP_RANK = FIDX_W'(FRAMES - 1);

   logic [FIDX_W-1:0] touched_rank;

   always_comb begin
      touched_rank = rank[touch_frame];
      for (int i = 0; i < FRAMES; i++) begin
         if (!touch) begin
            rank_next[i] = rank[i];
         end else if (FIDX_W'(i) == touch_frame) begin
            rank_next[i] = TOP_RANK;
         end else if (rank[i] > touched_rank) begin
            rank_next[i] = rank[i] - 1'b1;
         end else begin
            rank_next[i] = rank[i];
         end
      end
   end

endmodule

/* dv/tb.sv */
// testbench for the lru page frame manager: directed table, then checked random traffic
`timescale 1ns / 1ps

module tb;

   localparam int NUM_FRAMES  = lpfm_pkg::DEF_FRAMES;
   localparam int NUM_DIR     = 17;
   localparam int POOL_SIZE   = 10;
   localparam int CYCLE_LIMIT = 200000;
   localparam int REPORT_W    = lpfm_pkg::PAGE_W;

   typedef struct packed {
      logic                          hit;
      logic [lpfm_pkg::FRAME_W-1:0]  frame;
      logic [lpfm_pkg::OFFSET_W-1:0] offset;
      logic [lpfm_pkg::PAGE_W-1:0]   fill_page;
      logic                          writeback;
      logic [lpfm_pkg::PAGE_W-1:0]   writeback_page;
   } page_result_type;

   typedef struct packed {
      logic                         op;
      logic [lpfm_pkg::INDEX_W-1:0] index;
      logic                         typed;
      page_result_type              want;
   } dir_row_type;

   logic                          clock;
   logic                          reset;
   logic                          start;
   logic                          busy;
   logic                          req_op;
   logic [lpfm_pkg::INDEX_W-1:0]  req_index;
   logic                          rsp_strobe;
   logic                          rsp_hit;
   logic [lpfm_pkg::FRAME_W-1:0]  rsp_frame;
   logic [lpfm_pkg::OFFSET_W-1:0] rsp_offset;
   logic [lpfm_pkg::PAGE_W-1:0]   rsp_fill_page;
   logic                          rsp_writeback;
   logic [lpfm_pkg::PAGE_W-1:0]   rsp_writeback_page;

   logic [lpfm_pkg::PAGE_W-1:0]   page_tag  [NUM_FRAMES];
   logic                          tag_valid [NUM_FRAMES];
   logic                          tag_dirty [NUM_FRAMES];
   logic [lpfm_pkg::FRAME_W-1:0]  lru_rank  [NUM_FRAMES];

   page_result_type               pending_results [$];
   dir_row_type                   beat_table [NUM_DIR];
   logic [lpfm_pkg::PAGE_W-1:0]   page_pool [POOL_SIZE];
   int                            mismatch_count = 0;
   int                            cycle_count = 0;
   int                            idle_pct = 0;

   lru_page_frame_manager dut (
      .clock              (clock),
      .reset              (reset),
      .start              (start),
      .busy               (busy),
      .req_op             (req_op),
      .req_index          (req_index),
      .rsp_strobe         (rsp_strobe),
      .rsp_hit            (rsp_hit),
      .rsp_frame          (rsp_frame),
      .rsp_offset         (rsp_offset),
      .rsp_fill_page      (rsp_fill_page),
      .rsp_writeback      (rsp_writeback),
      .rsp_writeback_page (rsp_writeback_page)
   );

   always begin
      clock = 1'b1;
      #4;
      clock = 1'b0;
      #4;
   end

   function automatic void promote_frame(int f);
      logic [lpfm_pkg::FRAME_W-1:0] r;
      r = lru_rank[f];
      for (int i = 0; i < NUM_FRAMES; i++) begin
         if (lru_rank[i] > r) begin
            lru_rank[i] = lru_rank[i] - 1'b1;
         end
      end
      lru_rank[f] = lpfm_pkg::FRAME_W'(NUM_FRAMES - 1);
   endfunction

   function automatic page_result_type resolve_request(logic op,
                                                      logic [lpfm_pkg::INDEX_W-1:0] idx);
      page_result_type             r;
      logic [lpfm_pkg::PAGE_W-1:0] page;
      int                          f;
      int                          v;
      r = '0;
      page = idx[lpfm_pkg::INDEX_W-1:lpfm_pkg::OFFSET_W];
      r.offset = idx[lpfm_pkg::OFFSET_W-1:0];
      f = -1;
      for (int i = 0; i < NUM_FRAMES; i++) begin
         if (f < 0 && tag_valid[i] && page_tag[i] == page) begin
            f = i;
         end
      end
      if (op == lpfm_pkg::OP_MARK_DIRTY) begin
         if (f >= 0) begin
            tag_dirty[f] = 1'b1;
            r.hit = 1'b1;
            r.frame = lpfm_pkg::FRAME_W'(f);
         end
      end else if (f >= 0) begin
         promote_frame(f);
         r.hit = 1'b1;
         r.frame = lpfm_pkg::FRAME_W'(f);
      end else begin
         v = -1;
         for (int i = 0; i < NUM_FRAMES; i++) begin
            if (v < 0 && !tag_valid[i]) begin
               v = i;
            end
         end
         for (int i = 0; i < NUM_FRAMES; i++) begin
            if (v < 0 && lru_rank[i] == 0) begin
               v = i;
            end
         end
         if (tag_valid[v] && tag_dirty[v]) begin
            r.writeback = 1'b1;
            r.writeback_page = page_tag[v];
         end
         page_tag[v] = page;
         tag_valid[v] = 1'b1;
         tag_dirty[v] = 1'b0;
         promote_frame(v);
         r.frame = lpfm_pkg::FRAME_W'(v);
         r.fill_page = page;
      end
      return r;
   endfunction

   task automatic report_mismatch(string what, logic [REPORT_W-1:0] want,
                                  logic [REPORT_W-1:0] got);
      $display("%0t mismatch on %s: expected %h, got %h", $time, what, want, got);
      mismatch_count++;
   endtask

   task automatic issue_request(logic op, logic [lpfm_pkg::INDEX_W-1:0] idx, logic typed,
                                page_result_type want);
      page_result_type pred;
      while ($urandom_range(0, 99) < idle_pct) begin
         start <= 1'b0;
         @(posedge clock);
      end
      start     <= 1'b1;
      req_op    <= op;
      req_index <= idx;
      do @(posedge clock); while (busy !== 1'b0);
      pred = resolve_request(op, idx);
      pending_results.push_back(typed ? want : pred);
   endtask

   // result beats: compare each against the oldest outstanding expectation
   always @(posedge clock) begin
      page_result_type exp_beat;
      if (rsp_strobe === 1'b1) begin
         if (pending_results.size() == 0) begin
            report_mismatch("beat with nothing pending", REPORT_W'(0), REPORT_W'(1));
         end else begin
            exp_beat = pending_results.pop_front();
            if (rsp_hit !== exp_beat.hit)
               report_mismatch("hit", REPORT_W'(exp_beat.hit), REPORT_W'(rsp_hit));
            if (rsp_frame !== exp_beat.frame)
               report_mismatch("frame", REPORT_W'(exp_beat.frame), REPORT_W'(rsp_frame));
            if (rsp_offset !== exp_beat.offset)
               report_mismatch("offset", REPORT_W'(exp_beat.offset), REPORT_W'(rsp_offset));
            if (rsp_fill_page !== exp_beat.fill_page)
               report_mismatch("fill_page", exp_beat.fill_page, rsp_fill_page);
            if (rsp_writeback !== exp_beat.writeback)
               report_mismatch("writeback", REPORT_W'(exp_beat.writeback),
                               REPORT_W'(rsp_writeback));
            if (rsp_writeback_page !== exp_beat.writeback_page)
               report_mismatch("writeback_page", exp_beat.writeback_page,
                               rsp_writeback_page);
         end
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("== FAIL ==");
         $finish;
      end
   end

   initial begin
      logic                         op;
      logic [lpfm_pkg::INDEX_W-1:0] idx;
      int                           phase_pct [4];
      reset     = 1'b1;
      start     = 1'b0;
      req_op    = lpfm_pkg::OP_ACCESS;
      req_index = '0;
      for (int i = 0; i < NUM_FRAMES; i++) begin
         page_tag[i]  = '0;
         tag_valid[i] = 1'b0;
         tag_dirty[i] = 1'b0;
         lru_rank[i]  = lpfm_pkg::FRAME_W'(i);
      end
      phase_pct = '{0, 67, 0, 12};
      beat_table = '{
         // empty frames never hit, even on page zero
         '{lpfm_pkg::OP_MARK_DIRTY, 24'h000000, 1'b1,
           '{1'b0, 3'd0, 8'h00, 16'h0000, 1'b0, 16'h0000}},
         '{lpfm_pkg::OP_ACCESS,     24'h000000, 1'b1,
           '{1'b0, 3'd0, 8'h00, 16'h0000, 1'b0, 16'h0000}},
         '{lpfm_pkg::OP_ACCESS,     24'hFFFFFF, 1'b1,
           '{1'b0, 3'd1, 8'hFF, 16'hFFFF, 1'b0, 16'h0000}},
         '{lpfm_pkg::OP_ACCESS,     24'h0000FF, 1'b1,
           '{1'b1, 3'd0, 8'hFF, 16'h0000, 1'b0, 16'h0000}},
         '{lpfm_pkg::OP_MARK_DIRTY, 24'hFFFF00, 1'b1,
           '{1'b1, 3'd1, 8'h00, 16'h0000, 1'b0, 16'h0000}},
         '{lpfm_pkg::OP_ACCESS,     24'h000100, 1'b0, '0},
         '{lpfm_pkg::OP_ACCESS,     24'h000201, 1'b0, '0},
         '{lpfm_pkg::OP_ACCESS,     24'h000302, 1'b0, '0},
         '{lpfm_pkg::OP_ACCESS,     24'h000403, 1'b0, '0},
         // all frames full: least recent dirty frame is written back
         '{lpfm_pkg::OP_ACCESS,     24'h000500, 1'b1,
           '{1'b0, 3'd1, 8'h00, 16'h0005, 1'b1, 16'hFFFF}},
         '{lpfm_pkg::OP_ACCESS,     24'h000080, 1'b0, '0},
         '{lpfm_pkg::OP_MARK_DIRTY, 24'h0002AB, 1'b0, '0},
         '{lpfm_pkg::OP_ACCESS,     24'h000600, 1'b0, '0},
         '{lpfm_pkg::OP_MARK_DIRTY, 24'h123456, 1'b0, '0},
         '{lpfm_pkg::OP_ACCESS,     24'h123456, 1'b0, '0},
         '{lpfm_pkg::OP_MARK_DIRTY, 24'hAAAA55, 1'b0, '0},
         '{lpfm_pkg::OP_ACCESS,     24'h555555, 1'b0, '0}
      };
      for (int i = 0; i < POOL_SIZE; i++) begin
         page_pool[i] = lpfm_pkg::PAGE_W'($urandom);
      end

      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      for (int i = 0; i < NUM_DIR; i++) begin
         issue_request(beat_table[i].op, beat_table[i].index, beat_table[i].typed,
                       beat_table[i].want);
      end

      // random traffic over a small page pool so hits, evictions and writebacks recur
      for (int p = 0; p < 4; p++) begin
         idle_pct = phase_pct[p];
         for (int n = 0; n < 100; n++) begin
            op = ($urandom_range(0, 99) < 30) ? lpfm_pkg::OP_MARK_DIRTY
                                               : lpfm_pkg::OP_ACCESS;
            if ($urandom_range(0, 99) < 15) begin
               idx = lpfm_pkg::INDEX_W'($urandom);
            end else begin
               idx = {page_pool[$urandom_range(0, POOL_SIZE - 1)],
                      lpfm_pkg::OFFSET_W'($urandom)};
            end
            if ($urandom_range(0, 99) < 5) begin
               page_pool[$urandom_range(0, POOL_SIZE - 1)] = lpfm_pkg::PAGE_W'($urandom);
            end
            issue_request(op, idx, 1'b0, '0);
         end
      end

      start <= 1'b0;
      while (pending_results.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("== PASS ==");
      end else begin
         $display("== FAIL ==");
      end
      $finish;
   end

endmodule
